[sv/fqa_pkg.sv]
// Shared widths, opcodes and item structs for the Q24.8 fixed-point ALU.
// No dependencies; every other file imports this package.
package fqa_pkg;

    // Word and fraction widths of the raw fixed-point values
    localparam int WORD_W = 32;
    localparam int FRAC_W = 8;

    // Derived widths
    localparam int QUOT_W   = WORD_W + FRAC_W;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int OPCODE_W = 4;

    // Stream widths, filled up to whole bytes
    localparam int S_TDATA_W = ((2 * WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((WORD_W + 7) / 8) * 8;
    localparam int S_TUSER_W = OPCODE_W;
    localparam int M_TUSER_W = 3;

    // Operation codes
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_FROMINT = 4'd14,
        OP_TOINT   = 4'd15
    } op_t;

    // Result of every operation other than divide, known early in the pipe
    typedef struct packed {
        logic [WORD_W-1:0] res;
        logic              cmp;
        logic              ovf;
    } early_t;

    // Side information that rides along with the divider stages
    typedef struct packed {
        logic   is_div;
        logic   neg;
        logic   bzero;
        early_t early;
    } tag_t;

    // One finished result item
    typedef struct packed {
        logic [WORD_W-1:0] res;
        logic              cmp;
        logic              ovf;
        logic              dz;
    } item_t;

endpackage

[sv/fqa_mul.sv]
// Two-stage fixed-point multiplier on operand magnitudes: product, then
// fraction shift, overflow check and sign. Depends on fqa_pkg.
module fqa_mul (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [fqa_pkg::WORD_W-1:0] mag_a,
    input  logic [fqa_pkg::WORD_W-1:0] mag_b,
    input  logic                      neg,
    output logic [fqa_pkg::WORD_W-1:0] res,
    output logic                      ovf
);
    import fqa_pkg::*;

    localparam int SHIFT_W = PROD_W - FRAC_W;

    logic [PROD_W-1:0]  prod_reg;
    logic               neg_reg;
    logic [WORD_W-1:0]  res_reg, res_next;
    logic               ovf_reg, ovf_next;
    logic [SHIFT_W-1:0] shifted;
    logic [SHIFT_W-1:0] limit;
    logic [SHIFT_W-1:0] negated;

    // Drop the fraction bits, check the range for the sign and apply the sign
    always_comb begin
        shifted  = prod_reg[PROD_W-1:FRAC_W];
        limit    = {{(SHIFT_W-WORD_W){1'b0}}, neg_reg, {(WORD_W-1){~neg_reg}}};
        negated  = '0 - shifted;
        ovf_next = shifted > limit;
        res_next = neg_reg ? negated[WORD_W-1:0] : shifted[WORD_W-1:0];
    end

    // Multiply stage, then finish stage
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= PROD_W'(mag_a) * PROD_W'(mag_b);
            neg_reg  <= neg;
            res_reg  <= res_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;

endmodule

[sv/fqa_div.sv]
// Pipelined restoring divider: one quotient bit per stage, QUOT_W stages,
// side tag carried with each stage. Depends on fqa_pkg.
module fqa_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  fqa_pkg::tag_t             in_tag,
    input  logic [fqa_pkg::WORD_W-1:0] in_num,
    input  logic [fqa_pkg::WORD_W-1:0] in_den,
    output logic                      out_valid,
    output fqa_pkg::tag_t             out_tag,
    output logic [fqa_pkg::QUOT_W-1:0] out_quot
);
    import fqa_pkg::*;

    // Stage registers; stage k holds the state after k quotient bits
    logic              valid_reg [1:QUOT_W];
    tag_t              tag_reg   [1:QUOT_W];
    logic [WORD_W-1:0] rem_reg   [1:QUOT_W];
    logic [QUOT_W-1:0] nq_reg    [1:QUOT_W];
    logic [WORD_W-1:0] den_reg   [1:QUOT_W];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic              cur_valid;
        tag_t              cur_tag;
        logic [WORD_W-1:0] cur_rem;
        logic [QUOT_W-1:0] cur_nq;
        logic [WORD_W-1:0] cur_den;
        logic [WORD_W:0]   trial;
        logic [WORD_W:0]   diff;
        logic              fits;
        logic [WORD_W-1:0] rem_next;
        logic [QUOT_W-1:0] nq_next;

        if (k == 0) begin : g_first
            assign cur_valid = in_valid;
            assign cur_tag   = in_tag;
            assign cur_rem   = '0;
            assign cur_nq    = {in_num, {FRAC_W{1'b0}}};
            assign cur_den   = in_den;
        end else begin : g_rest
            assign cur_valid = valid_reg[k];
            assign cur_tag   = tag_reg[k];
            assign cur_rem   = rem_reg[k];
            assign cur_nq    = nq_reg[k];
            assign cur_den   = den_reg[k];
        end

        // Shift in the next dividend bit, subtract where it fits
        always_comb begin
            trial    = {cur_rem, cur_nq[QUOT_W-1]};
            diff     = trial - {1'b0, cur_den};
            fits     = trial >= {1'b0, cur_den};
            rem_next = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            nq_next  = {cur_nq[QUOT_W-2:0], fits};
        end

        // Advance the valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= cur_valid;
            end
        end

        // Advance the payload
        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[k+1] <= cur_tag;
                rem_reg[k+1] <= rem_next;
                nq_reg[k+1]  <= nq_next;
                den_reg[k+1] <= cur_den;
            end
        end
    end

    // Dividend bits are all shifted out; the word now holds the quotient
    assign out_valid = valid_reg[QUOT_W];
    assign out_tag   = tag_reg[QUOT_W];
    assign out_quot  = nq_reg[QUOT_W];

endmodule

[sv/fqa_skid.sv]
// Output register with one skid entry; parts the result channel from the
// pipeline enable. Depends on fqa_pkg.
module fqa_skid (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  fqa_pkg::item_t in_item,
    output logic           in_ready,
    output logic           out_valid,
    output fqa_pkg::item_t out_item,
    input  logic           out_ready
);
    import fqa_pkg::*;

    logic  out_valid_reg, out_valid_next;
    item_t out_item_reg, out_item_next;
    logic  skid_valid_reg, skid_valid_next;
    item_t skid_item_reg, skid_item_next;
    logic  take;

    // Load the output from the skid entry first, else from the pipeline
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        take            = out_valid_reg && out_ready;
        if (skid_valid_reg) begin
            if (take) begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || take) begin
            out_valid_next = in_valid;
            out_item_next  = in_item;
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_item_next  = in_item;
        end
    end

    // Hold the valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold the payloads
    always_ff @(posedge aclk) begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[sv/fixed_point_q24_8_alu_top.sv]
// Top level of the Q24.8 fixed-point ALU: input stage, simple operations,
// multiplier, divider, result select and output buffer.
// Depends on fqa_pkg, fqa_mul, fqa_div and fqa_skid.
//
// Usage: one request on the slave stream carries an opcode (s_axis_tuser)
// and two signed raw operands (s_axis_tdata); each request gives exactly one
// result on the master stream, in request order. The result word is in
// m_axis_tdata, the compare, overflow and divide-by-zero flags in
// m_axis_tuser.
// Path: from the accepting edge to m_axis_tvalid a request passes stages 1
// to 4, the divider (one quotient bit per stage over QUOT_W stages), the
// final stage register and the output register; every operation takes the
// same path length so results stay in order.
// Throughput: one request per cycle, sustained while the receiver takes
// results.
// Reset: aresetn low clears every valid bit; the pipeline and output are
// empty afterwards and s_axis_tready is high.
// Stall: with m_axis_tready low the held result stays on the port, one more
// result goes into a skid entry, then s_axis_tready falls and the whole
// pipeline holds until the receiver takes again; nothing is lost or repeated.
module fixed_point_q24_8_alu_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slave stream: tdata = operand_a, operand_b; tuser = opcode
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [fqa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [fqa_pkg::S_TUSER_W-1:0] s_axis_tuser,
    // master stream: tdata = result; tuser = compare_true, overflow,
    // divide_by_zero
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [fqa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [fqa_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import fqa_pkg::*;

    logic en;

    // Stage 1: input registers
    logic              p1_valid_reg;
    op_t               p1_op_reg;
    logic [WORD_W-1:0] p1_a_reg, p1_b_reg;

    // Stage 2: simple results and magnitudes
    logic              p2_valid_reg;
    op_t               p2_op_reg;
    early_t            p2_early_reg, p2_early_next;
    logic [WORD_W-1:0] p2_ma_reg, p2_ma_next;
    logic [WORD_W-1:0] p2_mb_reg, p2_mb_next;
    logic              p2_neg_reg, p2_neg_next;
    logic              p2_bzero_reg, p2_bzero_next;

    // Stages 3 and 4: wait for the multiplier
    logic              p3_valid_reg, p4_valid_reg;
    op_t               p3_op_reg, p4_op_reg;
    early_t            p3_early_reg, p4_early_reg;
    logic [WORD_W-1:0] p3_ma_reg, p4_ma_reg;
    logic [WORD_W-1:0] p3_mb_reg, p4_mb_reg;
    logic              p3_neg_reg, p4_neg_reg;
    logic              p3_bzero_reg, p4_bzero_reg;

    // Multiplier and divider links
    logic [WORD_W-1:0] mul_res;
    logic              mul_ovf;
    tag_t              div_in_tag;
    logic              div_out_valid;
    tag_t              div_out_tag;
    logic [QUOT_W-1:0] div_out_quot;

    // Final stage
    logic              fin_valid_reg;
    item_t             fin_item_reg, fin_item_next;
    item_t             out_item;

    // Stage 2 arithmetic
    logic signed [WORD_W-1:0] sa, sb;
    logic [WORD_W-1:0]        sum, dif, inc_val, dec_val, neg_a, neg_b;
    logic                     a_lt_b, b_lt_a, a_eq_b;
    logic [FRAC_W:0]          a_top;

    // Final stage arithmetic
    logic [QUOT_W-1:0] q_limit;
    logic [QUOT_W-1:0] q_neg;

    // Compute the simple results, magnitudes and flags
    always_comb begin
        sa      = $signed(p1_a_reg);
        sb      = $signed(p1_b_reg);
        sum     = p1_a_reg + p1_b_reg;
        dif     = p1_a_reg - p1_b_reg;
        inc_val = p1_a_reg + WORD_W'(1);
        dec_val = p1_a_reg - WORD_W'(1);
        neg_a   = '0 - p1_a_reg;
        neg_b   = '0 - p1_b_reg;
        a_lt_b  = sa < sb;
        b_lt_a  = sb < sa;
        a_eq_b  = p1_a_reg == p1_b_reg;
        a_top   = p1_a_reg[WORD_W-1:WORD_W-1-FRAC_W];

        p2_ma_next    = p1_a_reg[WORD_W-1] ? neg_a : p1_a_reg;
        p2_mb_next    = p1_b_reg[WORD_W-1] ? neg_b : p1_b_reg;
        p2_neg_next   = p1_a_reg[WORD_W-1] ^ p1_b_reg[WORD_W-1];
        p2_bzero_next = p1_b_reg == '0;

        p2_early_next = '0;
        unique case (p1_op_reg)
            OP_ADD: begin
                p2_early_next.res = sum;
                p2_early_next.ovf = (p1_a_reg[WORD_W-1] == p1_b_reg[WORD_W-1])
                                    && (sum[WORD_W-1] != p1_a_reg[WORD_W-1]);
            end
            OP_SUB: begin
                p2_early_next.res = dif;
                p2_early_next.ovf = (p1_a_reg[WORD_W-1] != p1_b_reg[WORD_W-1])
                                    && (dif[WORD_W-1] != p1_a_reg[WORD_W-1]);
            end
            OP_MUL, OP_DIV: begin
                p2_early_next = '0;
            end
            OP_GT: p2_early_next.cmp = b_lt_a;
            OP_LT: p2_early_next.cmp = a_lt_b;
            OP_GE: p2_early_next.cmp = !a_lt_b;
            OP_LE: p2_early_next.cmp = !b_lt_a;
            OP_EQ: p2_early_next.cmp = a_eq_b;
            OP_NE: p2_early_next.cmp = !a_eq_b;
            OP_MIN: p2_early_next.res = a_lt_b ? p1_a_reg : p1_b_reg;
            OP_MAX: p2_early_next.res = b_lt_a ? p1_a_reg : p1_b_reg;
            OP_INC: begin
                p2_early_next.res = inc_val;
                p2_early_next.ovf = !p1_a_reg[WORD_W-1] && inc_val[WORD_W-1];
            end
            OP_DEC: begin
                p2_early_next.res = dec_val;
                p2_early_next.ovf = p1_a_reg[WORD_W-1] && !dec_val[WORD_W-1];
            end
            OP_FROMINT: begin
                p2_early_next.res = p1_a_reg << FRAC_W;
                p2_early_next.ovf = !((&a_top) || !(|a_top));
            end
            OP_TOINT: begin
                p2_early_next.res = WORD_W'(sa >>> FRAC_W);
            end
        endcase
    end

    // Advance the valid bits of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= s_axis_tvalid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    // Advance the payload of the front stages
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_op_reg    <= op_t'(s_axis_tuser[OPCODE_W-1:0]);
            p1_a_reg     <= s_axis_tdata[WORD_W-1:0];
            p1_b_reg     <= s_axis_tdata[2*WORD_W-1:WORD_W];
            p2_op_reg    <= p1_op_reg;
            p2_early_reg <= p2_early_next;
            p2_ma_reg    <= p2_ma_next;
            p2_mb_reg    <= p2_mb_next;
            p2_neg_reg   <= p2_neg_next;
            p2_bzero_reg <= p2_bzero_next;
            p3_op_reg    <= p2_op_reg;
            p3_early_reg <= p2_early_reg;
            p3_ma_reg    <= p2_ma_reg;
            p3_mb_reg    <= p2_mb_reg;
            p3_neg_reg   <= p2_neg_reg;
            p3_bzero_reg <= p2_bzero_reg;
            p4_op_reg    <= p3_op_reg;
            p4_early_reg <= p3_early_reg;
            p4_ma_reg    <= p3_ma_reg;
            p4_mb_reg    <= p3_mb_reg;
            p4_neg_reg   <= p3_neg_reg;
            p4_bzero_reg <= p3_bzero_reg;
        end
    end

    // Multiply magnitudes over stages 3 and 4
    fqa_mul u_mul (
        .aclk  (aclk),
        .en    (en),
        .mag_a (p2_ma_reg),
        .mag_b (p2_mb_reg),
        .neg   (p2_neg_reg),
        .res   (mul_res),
        .ovf   (mul_ovf)
    );

    // Merge the multiply result into the tag that rides with the divider
    always_comb begin
        div_in_tag        = '0;
        div_in_tag.is_div = p4_op_reg == OP_DIV;
        div_in_tag.neg    = p4_neg_reg;
        div_in_tag.bzero  = p4_bzero_reg;
        div_in_tag.early  = p4_early_reg;
        if (p4_op_reg == OP_MUL) begin
            div_in_tag.early.res = mul_res;
            div_in_tag.early.ovf = mul_ovf;
            div_in_tag.early.cmp = 1'b0;
        end
    end

    fqa_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p4_valid_reg),
        .in_tag    (div_in_tag),
        .in_num    (p4_ma_reg),
        .in_den    (p4_mb_reg),
        .out_valid (div_out_valid),
        .out_tag   (div_out_tag),
        .out_quot  (div_out_quot)
    );

    // Sign the quotient, check its range and pick the final result
    always_comb begin
        q_limit = {{FRAC_W{1'b0}}, div_out_tag.neg, {(WORD_W-1){~div_out_tag.neg}}};
        q_neg   = '0 - div_out_quot;
        fin_item_next.res = div_out_tag.early.res;
        fin_item_next.cmp = div_out_tag.early.cmp;
        fin_item_next.ovf = div_out_tag.early.ovf;
        fin_item_next.dz  = 1'b0;
        if (div_out_tag.is_div) begin
            fin_item_next.cmp = 1'b0;
            if (div_out_tag.bzero) begin
                fin_item_next.res = '0;
                fin_item_next.ovf = 1'b0;
                fin_item_next.dz  = 1'b1;
            end else begin
                fin_item_next.res = div_out_tag.neg ? q_neg[WORD_W-1:0]
                                                    : div_out_quot[WORD_W-1:0];
                fin_item_next.ovf = div_out_quot > q_limit;
            end
        end
    end

    // Final stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_item_reg <= fin_item_next;
        end
    end

    // Output register and skid entry; its ready enables the whole pipeline
    fqa_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fin_valid_reg),
        .in_item   (fin_item_reg),
        .in_ready  (en),
        .out_valid (m_axis_tvalid),
        .out_item  (out_item),
        .out_ready (m_axis_tready)
    );

    assign s_axis_tready = en;
    assign m_axis_tdata  = M_TDATA_W'(out_item.res);
    assign m_axis_tuser  = {out_item.dz, out_item.ovf, out_item.cmp};

endmodule
